[hw/rtl/kmsd_pkg.sv]
// types, constants and key tables shared by the key matrix scan decoder
package kmsd_pkg;

  localparam int unsigned ROWS       = 9;
  localparam int unsigned COLS       = 7;
  localparam int unsigned MATRIX_W   = ROWS * COLS;
  localparam int unsigned TDATA_IN_W = 64;
  localparam int unsigned ROW_W      = 4;
  localparam int unsigned COL_W      = 3;
  localparam int unsigned HELD_W     = 6;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // matrix bit positions of the modifier keys
  localparam int unsigned POS_CTRL        = 7 * 8 + 3;
  localparam int unsigned POS_SHIFT       = 7 * 8 + 4;
  localparam int unsigned POS_SHIFT_ROW0  = 4;

  // control and shift of row 8 take no part in the held count
  localparam logic [MATRIX_W-1:0] SKIP_MASK =
    (MATRIX_W'(1) << POS_CTRL) | (MATRIX_W'(1) << POS_SHIFT);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL    = 1'd1;

  localparam logic [CFG_W-1:0] FIRST_DELAY_RST = 8'd50;
  localparam logic [CFG_W-1:0] INTERVAL_RST    = 8'd5;

  // control-mode character handling
  localparam logic [CODE_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CODE_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CODE_W-1:0] CH_CARET   = 8'h5E;
  localparam logic [CODE_W-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [CODE_W-1:0] CH_RBRACE  = 8'h7D;
  localparam logic [CODE_W-1:0] CH_BAR     = 8'h7C;
  localparam logic [CODE_W-1:0] CTRL_MASK  = 8'h1F;
  localparam logic [CODE_W-1:0] PRINT_LO   = 8'd32;
  localparam logic [CODE_W-1:0] PRINT_HI   = 8'd126;

  localparam logic [CODE_W-1:0] PLAIN_ROM [0:ROWS-1][0:COLS-1] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h68, 8'h62, 8'h35, 8'h66, 8'h78, 8'h74, 8'h92},
    '{8'h6A, 8'h6E, 8'h36, 8'h64, 8'h7A, 8'h79, 8'h90},
    '{8'h6B, 8'h6D, 8'h37, 8'h65, 8'h73, 8'h75, 8'h93},
    '{8'h6C, 8'h2C, 8'h38, 8'h77, 8'h61, 8'h69, 8'h91},
    '{8'h3B, 8'h2E, 8'h39, 8'h33, 8'h71, 8'h6F, 8'h3F},
    '{8'h3A, 8'h2F, 8'h30, 8'h32, 8'h31, 8'h70, 8'h5B},
    '{8'h67, 8'h76, 8'h34, 8'h63, 8'h20, 8'h72, 8'h5D},
    '{8'h08, 8'h0D, 8'h2D, 8'h00, 8'h00, 8'h40, 8'h7C}
  };

  localparam logic [CODE_W-1:0] SHIFT_ROM [0:ROWS-1][0:COLS-1] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h48, 8'h42, 8'h25, 8'h46, 8'h58, 8'h54, 8'h92},
    '{8'h4A, 8'h4E, 8'h26, 8'h44, 8'h5A, 8'h59, 8'h90},
    '{8'h4B, 8'h4D, 8'h27, 8'h45, 8'h53, 8'h55, 8'h93},
    '{8'h4C, 8'h3C, 8'h28, 8'h57, 8'h41, 8'h49, 8'h91},
    '{8'h2B, 8'h3E, 8'h29, 8'hA3, 8'h51, 8'h4F, 8'h3F},
    '{8'h2A, 8'h3F, 8'h5E, 8'h22, 8'h21, 8'h50, 8'h5C},
    '{8'h47, 8'h56, 8'h24, 8'h43, 8'h20, 8'h52, 8'h5F},
    '{8'h08, 8'h1B, 8'h3D, 8'h00, 8'h00, 8'h40, 8'h3F}
  };

  // what the scan tracker hands to the repeat logic and the decoder
  typedef struct packed {
    logic             new_press;
    logic             held_ok;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             shift;
    logic             ctrl;
  } scan_info_t;

endpackage

[hw/rtl/key_matrix_scan_decoder.sv]
// key matrix scan decoder top level: scan register, repeat timer, result register
//
// Takes one 9x7 active-low matrix scan per request and gives at most one key code per
// scan. A new scan is accepted every clock cycle while the input register can take it;
// each scan goes through the input register, then the single pass of edge detection, held-key
// count, repeat timer and table decode, then the result register. A stalled result
// blocks further scans only once the input register is also full. Scans that bring no
// emission (no new press, timer not expired, a held count outside one or two, or a
// table cell of zero) produce nothing. Delays are counted in scans; a value of zero
// makes the next expiry 256 scans away. No clearing pass after reset.
module key_matrix_scan_decoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [kmsd_pkg::TDATA_IN_W-1:0]   s_tdata,   // [62:0] matrix_raw
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [kmsd_pkg::CODE_W-1:0]       m_tdata,   // [7:0] key_code
  input  logic                              cfg_we,
  input  logic [kmsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmsd_pkg::CFG_W-1:0]        cfg_data
);
  import kmsd_pkg::*;

  logic                in_valid;
  logic [MATRIX_W-1:0] in_raw;
  logic                out_free;
  logic                step;
  logic [CFG_W-1:0]    first_delay;
  logic [CFG_W-1:0]    interval;
  logic [CFG_W-1:0]    timer;
  logic [CFG_W-1:0]    timer_next;
  logic [CFG_W-1:0]    timer_dec;
  logic                emit;
  logic                emit_nz;
  logic [CODE_W-1:0]   code;
  scan_info_t          info;

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_raw <= s_tdata[MATRIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay <= FIRST_DELAY_RST;
      interval    <= INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_DELAY: first_delay <= cfg_data;
        REG_INTERVAL:    interval    <= cfg_data;
        default: ;
      endcase
    end
  end

  kmsd_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cur  (~in_raw),
    .info (info)
  );

  kmsd_decode u_decode (
    .info (info),
    .code (code)
  );

  // typematic repeat: timer only moves while one or two keys are held
  assign timer_dec = timer - CFG_W'(1);

  always_comb begin
    timer_next = timer;
    emit       = 1'b0;
    if (info.held_ok) begin
      if (info.new_press) begin
        timer_next = first_delay;
        emit       = 1'b1;
      end else if (timer_dec == '0) begin
        timer_next = interval;
        emit       = 1'b1;
      end else begin
        timer_next = timer_dec;
      end
    end
  end

  assign emit_nz = emit && (code != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else if (step) begin
      timer <= timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= emit_nz;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit_nz) begin
      m_tdata <= code;
    end
  end

`ifndef SYNTHESIS
  a_no_zero_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata != '0))
    else $error("zero key code presented");

  a_emit_needs_hold: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |-> info.held_ok)
    else $error("key emitted outside one or two held keys");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("scan accepted while pipeline full");

  a_timer_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(timer))
    else $error("repeat timer moved without a scan");
`endif

endmodule

[hw/rtl/kmsd_scan.sv]
// scan tracker: edge detection, held key count and last new key position
module kmsd_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [kmsd_pkg::MATRIX_W-1:0]   cur,
  output kmsd_pkg::scan_info_t            info
);
  import kmsd_pkg::*;

  logic [MATRIX_W-1:0] prev;
  logic [HELD_W-1:0]   held;
  logic [ROW_W-1:0]    last_row;
  logic [COL_W-1:0]    last_col;

  logic [MATRIX_W-1:0] pressed;
  logic [MATRIX_W-1:0] released;
  logic [HELD_W-1:0]   held_next;
  logic [ROW_W-1:0]    last_row_next;
  logic [COL_W-1:0]    last_col_next;
  logic [COL_W-1:0]    row_col [0:ROWS-1];
  logic [ROWS-1:0]     row_hit;
  logic [ROW_W-1:0]    hit_row;
  logic [COL_W-1:0]    hit_col;
  logic                new_press;

  assign pressed   = cur & ~prev & ~SKIP_MASK;
  assign released  = ~cur & prev & ~SKIP_MASK;
  assign new_press = |pressed;
  assign held_next = held + HELD_W'($countones(pressed)) - HELD_W'($countones(released));

  // last pressed column within each row, rows scanned independently
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      row_hit[r] = |pressed[7*r +: 7];
      row_col[r] = '0;
      for (int c = 0; c < COLS; c++) begin
        if (pressed[7*r + c]) begin
          row_col[r] = COL_W'(c);
        end
      end
    end
  end

  // last row in scan order that saw a new press
  always_comb begin
    hit_row = '0;
    hit_col = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (row_hit[r]) begin
        hit_row = ROW_W'(r);
        hit_col = row_col[r];
      end
    end
  end

  assign last_row_next = new_press ? hit_row : last_row;
  assign last_col_next = new_press ? hit_col : last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev     <= '0;
      held     <= '0;
      last_row <= '0;
      last_col <= '0;
    end else if (step) begin
      prev     <= cur;
      held     <= held_next;
      last_row <= last_row_next;
      last_col <= last_col_next;
    end
  end

  always_comb begin
    info.new_press = new_press;
    info.held_ok   = held_next inside {6'd1, 6'd2};
    info.row       = last_row_next;
    info.col       = last_col_next;
    info.shift     = cur[POS_SHIFT] | cur[POS_SHIFT_ROW0];
    info.ctrl      = cur[POS_CTRL];
  end

endmodule

[hw/rtl/kmsd_decode.sv]
// key decoder: table lookup with shift and control handling
module kmsd_decode (
  input  kmsd_pkg::scan_info_t            info,
  output logic [kmsd_pkg::CODE_W-1:0]     code
);
  import kmsd_pkg::*;

  logic [CODE_W-1:0] raw;

  assign raw = info.shift ? SHIFT_ROM[info.row][info.col] : PLAIN_ROM[info.row][info.col];

  always_comb begin
    code = raw;
    if (info.ctrl) begin
      if (info.shift) begin
        case (raw)
          CH_LPAREN: code = CH_LBRACE;
          CH_RPAREN: code = CH_RBRACE;
          CH_CARET:  code = CH_BAR;
          default:   code = raw;
        endcase
      end else if (raw inside {[PRINT_LO:PRINT_HI]}) begin
        code = raw & CTRL_MASK;
      end
    end
  end

endmodule
